@@ rtl/vtfs_pkg.sv @@
// constants shared by the vlan tag filter and strip block
package vtfs_pkg;

  localparam int unsigned ADDR_BYTES = 12;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CNT_W      = $clog2(ADDR_BYTES + 1);

  localparam logic [15:0]      BYPASS_ID   = 16'hFFFF;
  localparam logic [7:0]       TPID_HI     = 8'h81;
  localparam logic [7:0]       TPID_LO     = 8'h00;

  localparam logic [POS_W-1:0] POS_TYPE_HI = POS_W'(12);
  localparam logic [POS_W-1:0] POS_TYPE_LO = POS_W'(13);
  localparam logic [POS_W-1:0] POS_TAG_HI  = POS_W'(14);
  localparam logic [POS_W-1:0] POS_TAG_LO  = POS_W'(15);
  localparam logic [POS_W-1:0] POS_SAT     = POS_W'(16);

endpackage

@@ rtl/vlan_tag_filter_strip.sv @@
// top level: vlan tag filter and strip over a byte stream
//
//  channel  signals                                             direction
//  input    in_valid in_stall frame_byte frame_end              in (in_stall out)
//  output   out_valid out_stall out_byte out_frame_end run_last out (out_stall in)
//  config   port_vlan_id_we port_vlan_id_data                   in
//
// one input beat per cycle unless draining or stalled, set by the single
// output register. a matching tag holds the input while the 12 address
// bytes drain from the head of the cell line into the output register.
// rst clears position, drop flag, drain counter, output valid and sets
// the vlan id to bypass. out_stall holds the output register and stalls input.
module vlan_tag_filter_strip (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_frame_end,
  output logic        run_last,
  input  logic        port_vlan_id_we,
  input  logic [15:0] port_vlan_id_data
);
  import vtfs_pkg::*;

  logic [15:0]      pvid;
  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       tag_hi, tag_hi_next;
  logic             drop, drop_next;
  logic             draining, draining_next;
  logic [CNT_W-1:0] drain_cnt, drain_cnt_next;
  logic             drain_end, drain_end_next;

  logic             can_load;
  logic             in_acc;
  logic             drain_step;
  logic             shift;
  logic             fwd;
  logic [11:0]      vid;
  logic [7:0]       cell_q [ADDR_BYTES];

  assign can_load   = !out_valid || !out_stall;
  assign in_stall   = draining || !can_load;
  assign in_acc     = in_valid && !in_stall;
  assign drain_step = draining && can_load;
  assign shift      = (in_acc && (pos < POS_W'(ADDR_BYTES))) || drain_step;
  assign vid        = {tag_hi[3:0], frame_byte};

  for (genvar i = 0; i < ADDR_BYTES; i++) begin : g_cell
    logic [7:0] din;
    if (i == ADDR_BYTES - 1) begin : g_tail
      assign din = frame_byte;
    end else begin : g_mid
      assign din = cell_q[i+1];
    end
    vtfs_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .din   (din),
      .dout  (cell_q[i])
    );
  end

  always_comb begin
    pos_next       = pos;
    tag_hi_next    = tag_hi;
    drop_next      = drop;
    draining_next  = draining;
    drain_cnt_next = drain_cnt;
    drain_end_next = drain_end;
    fwd            = 1'b0;
    if (drain_step) begin
      drain_cnt_next = drain_cnt - CNT_W'(1);
      if (drain_cnt == CNT_W'(1)) begin
        draining_next = 1'b0;
      end
    end
    if (in_acc) begin
      if (pvid == BYPASS_ID) begin
        fwd       = 1'b1;
        drop_next = 1'b1;
      end else begin
        case (pos)
          POS_TYPE_HI: begin
            if (frame_byte != TPID_HI) drop_next = 1'b1;
          end
          POS_TYPE_LO: begin
            if (frame_byte != TPID_LO) drop_next = 1'b1;
          end
          POS_TAG_HI: begin
            tag_hi_next = frame_byte;
          end
          POS_TAG_LO: begin
            if (drop || ({4'b0, vid} != pvid)) begin
              drop_next = 1'b1;
            end else begin
              draining_next  = 1'b1;
              drain_cnt_next = CNT_W'(ADDR_BYTES);
              drain_end_next = frame_end;
            end
          end
          default: begin
            if (pos >= POS_SAT && !drop) fwd = 1'b1;
          end
        endcase
      end
      if (frame_end) begin
        pos_next  = '0;
        drop_next = 1'b0;
      end else if (pos < POS_SAT) begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvid      <= BYPASS_ID;
      pos       <= '0;
      tag_hi    <= '0;
      drop      <= 1'b0;
      draining  <= 1'b0;
      drain_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (port_vlan_id_we) pvid <= port_vlan_id_data;
      pos       <= pos_next;
      tag_hi    <= tag_hi_next;
      drop      <= drop_next;
      draining  <= draining_next;
      drain_cnt <= drain_cnt_next;
      if (can_load) begin
        out_valid <= fwd || drain_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    drain_end <= drain_end_next;
    if (can_load) begin
      if (drain_step) begin
        out_byte      <= cell_q[0];
        out_frame_end <= (drain_cnt == CNT_W'(1)) && drain_end;
        run_last      <= (drain_cnt == CNT_W'(1));
      end else begin
        out_byte      <= frame_byte;
        out_frame_end <= frame_end;
        run_last      <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/vtfs_cell.sv @@
// one byte cell of the address hold line
module vtfs_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule
